// ===== design/qecv_pkg.sv =====
package qecv_pkg;

  localparam int CNT_W  = 32;
  localparam int TIME_W = 32;
  localparam int RES_W  = 48;
  localparam int PPR_W  = 16;
  localparam int CPR_W  = 18;
  localparam int NUM_W  = 83;
  localparam int DEN_W  = 34;
  localparam int TS_W   = 20;
  localparam int KPI_W  = 35;

  // 2*pi held as round(2*pi * 2^32).
  localparam logic [KPI_W-1:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic [19:0]      ONE_MILLION = 20'd1000000;
  localparam logic [TS_W-1:0]  TS_MAX_US   = 20'd500000;
  localparam logic [TS_W-1:0]  TS_DEF_US   = 20'd1000;
  localparam logic [TIME_W-1:0] HOLD_MAX_US = 32'd100000;

  localparam logic [RES_W-1:0] MAX48 = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] MIN48 = {1'b1, {(RES_W-1){1'b0}}};

  localparam logic [PPR_W-1:0] PPR_RESET = 16'd2048;

  localparam logic [1:0] CFG_PPR  = 2'd0;
  localparam logic [1:0] CFG_QUAD = 2'd1;
  localparam logic [1:0] CFG_IDX  = 2'd2;

  typedef enum logic [1:0] {
    OP_A_EDGE = 2'd0,
    OP_B_EDGE = 2'd1,
    OP_INDEX  = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  // Signed saturation of a magnitude to the 48-bit result range.
  function automatic logic [RES_W-1:0] sat48(input logic neg, input logic [NUM_W-1:0] mag);
    logic big;
    big = (mag > NUM_W'(MAX48));
    if (neg) begin
      sat48 = big ? MIN48 : RES_W'(-mag[RES_W-1:0]);
    end else begin
      sat48 = big ? MAX48 : mag[RES_W-1:0];
    end
  endfunction

endpackage

// ===== design/qecv_if.sv =====
interface qecv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        a_level;
  logic        b_level;
  logic        index_level;
  logic [31:0] time_us;

  modport source (output valid, operation, a_level, b_level, index_level, time_us,
                  input ready);
  modport sink (input valid, operation, a_level, b_level, index_level, time_us,
                output ready);
endinterface

interface qecv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] position_count;
  logic [47:0] angle_q16;
  logic [47:0] velocity_q16;
  logic        index_seen;
  logic        needs_search;

  modport source (output valid, position_count, angle_q16, velocity_q16, index_seen,
                  needs_search, input ready);
  modport sink (input valid, position_count, angle_q16, velocity_q16, index_seen,
                needs_search, output ready);
endinterface

// ===== design/qecv_div.sv =====
module qecv_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qecv_pkg::div_req_t  req_i,
  output qecv_pkg::div_rsp_t  rsp_o
);

  localparam int NW  = qecv_pkg::NUM_W;
  localparam int DW  = qecv_pkg::DEN_W;
  localparam int CBW = $clog2(NW);

  logic [NW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [DW-1:0]  den_q, den_d;
  logic [CBW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DW:0]    trial;
  logic           fits;

  // Restoring division, one quotient bit per cycle, numerator bits shifted in MSB first.
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CBW'(NW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== design/quadrature_encoder_counter_velocity.sv =====
// Channel   Dir  Handshake      Carries
// in_if     in   valid/ready    operation, a_level, b_level, index_level, time_us
// out_if    out  valid/ready    position_count, angle_q16, velocity_q16, index_seen,
//                               needs_search
// cfg       in   cfg_we_i only  cfg_idx_i selects the register, cfg_data_i the value
//
// One request is worked on at a time; in_if.ready is high only while the sequencer idles.
// Each request passes through the shared bit-serial divider, which yields 83 quotient bits
// per division: one division each for the angle and velocity scalings, and one more for
// the index rounding on a rising index edge or the rate division for a velocity sample
// that computes a new rate.
// Reset is asynchronous and active low; it clears the control and encoder state (not the
// datapath registers) and loads register defaults (2048 lines, quadrature on, index present).
// A finished result waits in the output register while a stalled sink holds it; a new
// request may be accepted meanwhile and is held in the last step until the register frees.
module quadrature_encoder_counter_velocity (
  input  logic        clk_i,
  input  logic        rst_ni,
  qecv_in_if.sink     in_if,
  qecv_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW = qecv_pkg::CNT_W;
  localparam int TW = qecv_pkg::TIME_W;
  localparam int RW = qecv_pkg::RES_W;
  localparam int NW = qecv_pkg::NUM_W;
  localparam int DW = qecv_pkg::DEN_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_IDX_START = 4'd1;
  localparam logic [3:0] S_IDX_WAIT  = 4'd2;
  localparam logic [3:0] S_IDX_APPLY = 4'd3;
  localparam logic [3:0] S_VEL_PRE   = 4'd4;
  localparam logic [3:0] S_VEL_DT    = 4'd5;
  localparam logic [3:0] S_VEL_CHK   = 4'd6;
  localparam logic [3:0] S_VEL_WAIT  = 4'd7;
  localparam logic [3:0] S_VEL_FIN   = 4'd8;
  localparam logic [3:0] S_SC_SET    = 4'd9;
  localparam logic [3:0] S_SC_MUL    = 4'd10;
  localparam logic [3:0] S_SC_START  = 4'd11;
  localparam logic [3:0] S_SC_WAIT   = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  logic [3:0] state_q;

  // Configuration registers.
  logic [qecv_pkg::PPR_W-1:0] ppr_q;
  logic                       quad_q;
  logic                       idxp_q;

  // Encoder state.
  logic [CW-1:0] pc_q;
  logic [TW-1:0] lpt_q;
  logic          a_last_q, b_last_q, ix_last_q, found_q;
  logic [TW-1:0] hold_q;
  logic [RW-1:0] rate_q;
  logic [CW-1:0] psc_q;
  logic [TW-1:0] pst_q;

  // Working registers for one request.
  logic [TW-1:0]               t_q;
  logic [qecv_pkg::TS_W-1:0]   ts_q;
  logic [TW-1:0]               th_q;
  logic [CW-1:0]               dn_q;
  logic [DW-1:0]               dt_q;
  logic [51:0]                 nprod_q;
  logic [CW-1:0]               nm_q;
  logic [RW-1:0]               mag_q;
  logic                        neg_q;
  logic [NW-1:0]               acc_q;
  logic [1:0]                  chunk_q;
  logic                        sel_q;
  logic [RW-1:0]               ang_q;
  logic [RW-1:0]               vel_q;

  // Output register.
  logic          out_valid_q;
  logic [CW-1:0] out_pc_q;
  logic [RW-1:0] out_ang_q, out_vel_q;
  logic          out_seen_q, out_search_q;

  qecv_pkg::div_req_t div_req;
  qecv_pkg::div_rsp_t div_rsp;

  logic [qecv_pkg::PPR_W-1:0] ppr_eff;
  logic [qecv_pkg::CPR_W-1:0] cpr;
  logic                       accept;
  logic                       out_free;
  logic [CW-1:0]              pc_mag;
  logic [RW-1:0]              rate_mag;
  logic [CW-1:0]              dn_mag;
  logic [TW-1:0]              ts_raw;
  logic                       ts_bad;
  logic [DW-1:0]              dt_calc;
  logic                       rate_cond;
  logic [CW:0]                q_round;
  logic [15:0]                chunk_val;
  logic [NW-1:0]              part_prod;
  logic [RW-1:0]              sc_res;
  logic [CW-1:0]              nv;

  // Counts per revolution: zero lines count as one, quadrature multiplies by four.
  assign ppr_eff = (ppr_q == '0) ? qecv_pkg::PPR_W'(1) : ppr_q;
  assign cpr     = quad_q ? {ppr_eff, 2'b00} : {2'b00, ppr_eff};

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  assign pc_mag   = pc_q[CW-1] ? CW'(-pc_q) : pc_q;
  assign rate_mag = rate_q[RW-1] ? RW'(-rate_q) : rate_q;
  assign dn_mag   = dn_q[CW-1] ? CW'(-dn_q) : dn_q;

  // Sample interval falls back to a millisecond when it is not positive or too long.
  assign ts_raw = t_q - pst_q;
  assign ts_bad = ts_raw[TW-1] || (ts_raw == '0) || (ts_raw > TW'(qecv_pkg::TS_MAX_US));

  assign dt_calc = DW'(ts_q) + {{(DW-TW){hold_q[TW-1]}}, hold_q}
                 - {{(DW-TW){th_q[TW-1]}}, th_q};
  assign rate_cond = (dn_q != '0)
                  && ($signed({dt_q, 1'b0}) > $signed({{(DW+1-qecv_pkg::TS_W){1'b0}}, ts_q}));

  // Index rounding: half away from zero on the magnitude.
  assign q_round = {1'b0, div_rsp.quo[CW-1:0]}
                 + ((DW'({div_rsp.rem, 1'b0}) >= DW'(cpr)) ? (CW+1)'(1) : '0);
  assign nv      = pc_q[CW-1] ? CW'(-nm_q) : nm_q;

  // Scaling by 2*pi is done as three 16-bit partial products of the magnitude.
  assign chunk_val = 16'(mag_q >> {chunk_q, 4'b0000});
  assign part_prod = NW'(NW'(chunk_val) * NW'(qecv_pkg::TWO_PI_Q32)) << {chunk_q, 4'b0000};
  assign sc_res    = qecv_pkg::sat48(neg_q, NW'(div_rsp.quo >> 32));

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NW'(acc_q);
    div_req.den   = DW'(cpr);
    unique case (state_q)
      S_IDX_START: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(pc_mag);
      end
      S_VEL_CHK: begin
        div_req.start = rate_cond;
        div_req.num   = NW'({nprod_q, 16'b0});
        div_req.den   = dt_q;
      end
      S_SC_START: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  qecv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= qecv_pkg::PPR_RESET;
      quad_q <= 1'b1;
      idxp_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qecv_pkg::CFG_PPR:  ppr_q  <= cfg_data_i;
        qecv_pkg::CFG_QUAD: quad_q <= cfg_data_i[0];
        qecv_pkg::CFG_IDX:  idxp_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      lpt_q       <= '0;
      a_last_q    <= 1'b0;
      b_last_q    <= 1'b0;
      ix_last_q   <= 1'b0;
      found_q     <= 1'b0;
      hold_q      <= '0;
      rate_q      <= '0;
      psc_q       <= '0;
      pst_q       <= '0;
      sel_q       <= 1'b0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register fills from the last step and empties when the sink takes it.
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sel_q   <= 1'b0;
            state_q <= S_SC_SET;
            unique case (qecv_pkg::op_e'(in_if.operation))
              qecv_pkg::OP_A_EDGE: begin
                if (quad_q) begin
                  if (in_if.a_level != a_last_q) begin
                    pc_q     <= (a_last_q == b_last_q) ? pc_q + 1'b1 : pc_q - 1'b1;
                    lpt_q    <= in_if.time_us;
                    a_last_q <= in_if.a_level;
                  end
                end else if (in_if.a_level && !in_if.b_level) begin
                  pc_q  <= pc_q + 1'b1;
                  lpt_q <= in_if.time_us;
                end
              end
              qecv_pkg::OP_B_EDGE: begin
                if (quad_q) begin
                  if (in_if.b_level != b_last_q) begin
                    pc_q     <= (a_last_q != b_last_q) ? pc_q + 1'b1 : pc_q - 1'b1;
                    lpt_q    <= in_if.time_us;
                    b_last_q <= in_if.b_level;
                  end
                end else if (in_if.b_level && !in_if.a_level) begin
                  pc_q  <= pc_q - 1'b1;
                  lpt_q <= in_if.time_us;
                end
              end
              qecv_pkg::OP_INDEX: begin
                if (idxp_q) begin
                  ix_last_q <= in_if.index_level;
                  if (in_if.index_level && !ix_last_q) begin
                    state_q <= S_IDX_START;
                  end
                end
              end
              qecv_pkg::OP_SAMPLE: begin
                state_q <= S_VEL_PRE;
              end
              default: begin
              end
            endcase
          end
        end
        S_IDX_START: state_q <= S_IDX_WAIT;
        S_IDX_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_IDX_APPLY;
          end
        end
        S_IDX_APPLY: begin
          // The previous sample count moves with the count so that velocity is unaffected.
          psc_q   <= psc_q + (nv - pc_q);
          pc_q    <= nv;
          found_q <= 1'b1;
          state_q <= S_SC_SET;
        end
        S_VEL_PRE: state_q <= S_VEL_DT;
        S_VEL_DT:  state_q <= S_VEL_CHK;
        S_VEL_CHK: state_q <= rate_cond ? S_VEL_WAIT : S_VEL_FIN;
        S_VEL_WAIT: begin
          if (div_rsp.done) begin
            rate_q  <= qecv_pkg::sat48(dn_q[CW-1], div_rsp.quo);
            state_q <= S_VEL_FIN;
          end
        end
        S_VEL_FIN: begin
          if (!th_q[TW-1] && (th_q > qecv_pkg::HOLD_MAX_US)) begin
            rate_q <= '0;
          end
          pst_q   <= t_q;
          hold_q  <= th_q;
          psc_q   <= pc_q;
          state_q <= S_SC_SET;
        end
        S_SC_SET: begin
          chunk_q <= '0;
          state_q <= S_SC_MUL;
        end
        S_SC_MUL: begin
          chunk_q <= chunk_q + 1'b1;
          if (chunk_q == 2'd2) begin
            state_q <= S_SC_START;
          end
        end
        S_SC_START: state_q <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (div_rsp.done) begin
            if (!sel_q) begin
              sel_q   <= 1'b1;
              state_q <= S_SC_SET;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q <= in_if.time_us;
    end
    if (state_q == S_VEL_PRE) begin
      ts_q <= ts_bad ? qecv_pkg::TS_DEF_US : ts_raw[qecv_pkg::TS_W-1:0];
      th_q <= t_q - lpt_q;
      dn_q <= pc_q - psc_q;
    end
    if (state_q == S_VEL_DT) begin
      dt_q    <= dt_calc;
      nprod_q <= 52'(dn_mag) * 52'(qecv_pkg::ONE_MILLION);
    end
    if ((state_q == S_IDX_WAIT) && div_rsp.done) begin
      nm_q <= CW'(q_round * (CW+1)'(cpr));
    end
    if (state_q == S_SC_SET) begin
      acc_q <= '0;
      if (!sel_q) begin
        neg_q <= pc_q[CW-1];
        mag_q <= RW'({pc_mag, 16'b0});
      end else begin
        neg_q <= rate_q[RW-1];
        mag_q <= rate_mag;
      end
    end
    if (state_q == S_SC_MUL) begin
      acc_q <= acc_q + part_prod;
    end
    if ((state_q == S_SC_WAIT) && div_rsp.done && !sel_q) begin
      ang_q <= sc_res;
    end
    if ((state_q == S_SC_WAIT) && div_rsp.done && sel_q) begin
      vel_q <= sc_res;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_pc_q     <= pc_q;
      out_ang_q    <= ang_q;
      out_vel_q    <= vel_q;
      out_seen_q   <= found_q;
      out_search_q <= idxp_q && !found_q;
    end
  end

  assign in_if.ready           = (state_q == S_IDLE);
  assign out_if.valid          = out_valid_q;
  assign out_if.position_count = out_pc_q;
  assign out_if.angle_q16      = out_ang_q;
  assign out_if.velocity_q16   = out_vel_q;
  assign out_if.index_seen     = out_seen_q;
  assign out_if.needs_search   = out_search_q;

`ifndef SYNTHESIS
  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(found_q))
    else $error("index found flag cleared");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a request");

  a_search_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.needs_search == (idxp_q && !out_if.index_seen)))
    else $error("needs_search inconsistent with index_seen");
`endif

endmodule
